// ===== rtl/core/salc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  localparam int SETS_MAX = 64;
  localparam int WAYS_MAX = 8;
  localparam int SET_W = $clog2(SETS_MAX);
  localparam int WAY_W = $clog2(WAYS_MAX);
  localparam int ADDR_W = 64;
  localparam int TAG_W = 64;
  localparam int STAMP_W = 64;
  localparam int CNT_W = 32;

  localparam int SBITS_W = 3;
  localparam int OBITS_W = 6;
  localparam int WAYS_CFG_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS = 2'd2;

  localparam logic [SBITS_W-1:0] SBITS_RESET = 3'd4;
  localparam logic [OBITS_W-1:0] OBITS_RESET = 6'd4;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 4'd1;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_STORE = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT = 2'd0;
  localparam logic [1:0] OUT_FILL = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  typedef struct packed {
    logic modify;
    logic [SET_W-1:0] set;
    logic [TAG_W-1:0] tag;
  } salc_req_t;

  typedef struct packed {
    logic valid;
    logic [TAG_W-1:0] tag;
    logic [STAMP_W-1:0] stamp;
  } salc_line_t;

  typedef salc_line_t [WAYS_MAX-1:0] salc_row_t;

  localparam int ROW_W = $bits(salc_row_t);

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                               input logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, cnt} + {{(CNT_W - 1){1'b0}}, inc};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/salc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/salc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module salc_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_wr_en,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] mode,
  input  wire logic [salc_pkg::ADDR_W-1:0] address,
  input  wire logic q_full,
  output logic q_push,
  output salc_pkg::salc_req_t q_data,
  output logic [salc_pkg::WAYS_CFG_W-1:0] ways_in_use
);
  import salc_pkg::*;

  logic [SBITS_W-1:0] set_index_bits;
  logic [OBITS_W-1:0] offset_bits;
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0] set_mask;
  logic [OBITS_W:0] tag_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= SBITS_RESET;
      offset_bits <= OBITS_RESET;
      ways_in_use <= WAYS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SET_BITS: set_index_bits <= cfg_data[SBITS_W-1:0];
        CFG_OFFSET_BITS: offset_bits <= cfg_data[OBITS_W-1:0];
        CFG_WAYS: ways_in_use <= cfg_data[WAYS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    shifted = address >> offset_bits;
    set_mask = ~(SET_W'({SET_W{1'b1}} << set_index_bits));
    tag_shift = {1'b0, offset_bits} + {{(OBITS_W + 1 - SBITS_W){1'b0}}, set_index_bits};
    q_data.modify = (mode == MODE_MODIFY);
    q_data.set = shifted[SET_W-1:0] & set_mask;
    q_data.tag = tag_shift[OBITS_W] ? '0 : (address >> tag_shift[OBITS_W-1:0]);
  end

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

endmodule

`default_nettype wire

// ===== rtl/core/salc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module salc_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire salc_pkg::salc_req_t push_data,
  output logic full,
  input  wire logic pop,
  output salc_pkg::salc_req_t pop_data,
  output logic not_empty
);
  import salc_pkg::*;

  salc_req_t entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/salc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module salc_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire salc_pkg::salc_req_t q_data,
  output logic q_pop,
  input  wire logic [salc_pkg::WAYS_CFG_W-1:0] ways_in_use,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [1:0] outcome,
  output logic store_hit,
  output logic [salc_pkg::CNT_W-1:0] hit_total,
  output logic [salc_pkg::CNT_W-1:0] miss_total,
  output logic [salc_pkg::CNT_W-1:0] eviction_total
);
  import salc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic state;
  salc_req_t cur;
  logic cur_row_ok;
  logic [SETS_MAX-1:0] row_ok;
  logic [STAMP_W-1:0] clock;
  logic [CNT_W-1:0] hits;
  logic [CNT_W-1:0] misses;
  logic [CNT_W-1:0] evicts;

  logic [ROW_W-1:0] rd_bits;
  logic [ROW_W-1:0] wr_bits;
  salc_row_t rd_row;
  salc_row_t wr_row;

  logic [WAYS_CFG_W-1:0] eff_ways;
  logic [WAYS_MAX-1:0] used;
  logic [WAYS_MAX-1:0] vld;
  logic [WAYS_MAX-1:0] hit_vec;
  logic [WAYS_MAX-1:0] empty_vec;
  logic [WAYS_MAX-1:0] old_vec;
  logic hit;
  logic has_empty;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] empty_way;
  logic [WAY_W-1:0] old_way;
  logic [WAY_W-1:0] victim;
  logic [STAMP_W-1:0] stamp_new;
  logic [1:0] outcome_next;
  logic [1:0] hit_inc;
  logic fire;

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS_MAX)
  ) u_tag_ram (
    .clk(clk),
    .wr_en(fire),
    .wr_addr(cur.set),
    .wr_data(wr_bits),
    .rd_en(q_pop),
    .rd_addr(q_data.set),
    .rd_data(rd_bits)
  );

  assign rd_row = rd_bits;
  assign wr_bits = wr_row;

  assign q_pop = (state == ST_IDLE) && q_valid;
  assign fire = (state == ST_EVAL) && (!out_valid || !out_stall);

  always_comb begin
    if (ways_in_use == '0) begin
      eff_ways = WAYS_CFG_W'(1);
    end else if (ways_in_use > WAYS_CFG_W'(WAYS_MAX)) begin
      eff_ways = WAYS_CFG_W'(WAYS_MAX);
    end else begin
      eff_ways = ways_in_use;
    end

    for (int w = 0; w < WAYS_MAX; w++) begin
      used[w] = (WAYS_CFG_W'(w) < eff_ways);
      vld[w] = cur_row_ok && rd_row[w].valid;
      hit_vec[w] = used[w] && vld[w] && (rd_row[w].tag == cur.tag);
      empty_vec[w] = used[w] && !vld[w];
    end

    // A way is oldest when it is strictly below every lower way and no
    // higher way is strictly below it, so ties fall to the lower index.
    for (int w = 0; w < WAYS_MAX; w++) begin
      old_vec[w] = used[w];
      for (int v = 0; v < WAYS_MAX; v++) begin
        if (v < w && used[v] && !(rd_row[w].stamp < rd_row[v].stamp)) begin
          old_vec[w] = 1'b0;
        end
        if (v > w && used[v] && (rd_row[v].stamp < rd_row[w].stamp)) begin
          old_vec[w] = 1'b0;
        end
      end
    end

    hit = |hit_vec;
    has_empty = |empty_vec;
    hit_way = '0;
    empty_way = '0;
    old_way = '0;
    for (int w = WAYS_MAX - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < WAYS_MAX; w++) begin
      if (empty_vec[w]) begin
        empty_way = WAY_W'(w);
      end
      if (old_vec[w]) begin
        old_way = WAY_W'(w);
      end
    end

    if (hit) begin
      victim = hit_way;
      outcome_next = OUT_HIT;
    end else if (has_empty) begin
      victim = empty_way;
      outcome_next = OUT_FILL;
    end else begin
      victim = old_way;
      outcome_next = OUT_EVICT;
    end

    // A modify makes two accesses to the same line: the second always hits.
    stamp_new = clock + (cur.modify ? STAMP_W'(2) : STAMP_W'(1));
    hit_inc = {1'b0, hit} + {1'b0, cur.modify};

    for (int w = 0; w < WAYS_MAX; w++) begin
      wr_row[w].valid = vld[w];
      wr_row[w].tag = rd_row[w].tag;
      wr_row[w].stamp = rd_row[w].stamp;
    end
    wr_row[victim].valid = 1'b1;
    wr_row[victim].tag = cur.tag;
    wr_row[victim].stamp = stamp_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      row_ok <= '0;
      clock <= '0;
      hits <= '0;
      misses <= '0;
      evicts <= '0;
    end else begin
      if (q_pop) begin
        state <= ST_EVAL;
      end
      if (fire) begin
        state <= ST_IDLE;
        row_ok[cur.set] <= 1'b1;
        clock <= stamp_new;
        hits <= sat_add(hits, hit_inc);
        misses <= sat_add(misses, {1'b0, !hit});
        evicts <= sat_add(evicts, {1'b0, (outcome_next == OUT_EVICT)});
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
      cur_row_ok <= row_ok[q_data.set];
    end
    if (fire) begin
      outcome <= outcome_next;
      store_hit <= cur.modify;
    end
  end

  assign hit_total = hits;
  assign miss_total = misses;
  assign eviction_total = evicts;

  a_pop_to_eval: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_EVAL))
    else $error("Popped transaction did not enter evaluation.");

  a_one_victim: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && !hit && !has_empty) |-> $onehot(old_vec))
    else $error("Replacement choice is not a single way.");

  a_counts_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(hits) && $stable(misses) && $stable(evicts) && $stable(clock)))
    else $error("Counters changed without a completed transaction.");

  a_fire_shows: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("Completed transaction did not reach the output.");

endmodule

`default_nettype wire

// ===== rtl/core/set_assoc_lru_cache_model.sv =====
// Tag-only set-associative cache with least-recently-used replacement.
// Input channel: in_valid/in_stall carry one access (mode, address) per
// transaction. Output channel: out_valid/out_stall carry one result per
// access: outcome, store_hit and the running hit, miss and eviction totals.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 set index bits, 1 offset bits, 2 ways in use); write only while idle.
// The front stage splits the address into set and tag and pushes the access
// into a two-entry queue. The back stage pops an access and reads the set's
// row from the tag RAM, then in its evaluation state compares, picks a way
// and writes the row back once the output is free; it pops no new access
// until that write-back is done, so the RAM read and write-back of a row
// bound its throughput. The result is registered with the write-back.
// Reset clears the configuration to its defaults, the counters, the access
// clock and a valid bit per set, so no clearing pass is needed.
// While out_stall is high the result is held; the back stage then waits and
// the queue fills, after which in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_model (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_wr_en,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] mode,
  input  wire logic [salc_pkg::ADDR_W-1:0] address,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [1:0] outcome,
  output logic store_hit,
  output logic [salc_pkg::CNT_W-1:0] hit_total,
  output logic [salc_pkg::CNT_W-1:0] miss_total,
  output logic [salc_pkg::CNT_W-1:0] eviction_total
);
  import salc_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_not_empty;
  salc_req_t push_req;
  salc_req_t pop_req;
  logic [WAYS_CFG_W-1:0] ways_in_use;

  salc_front u_front (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .address(address),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(push_req),
    .ways_in_use(ways_in_use)
  );

  salc_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(push_req),
    .full(q_full),
    .pop(q_pop),
    .pop_data(pop_req),
    .not_empty(q_not_empty)
  );

  salc_back u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_not_empty),
    .q_data(pop_req),
    .q_pop(q_pop),
    .ways_in_use(ways_in_use),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .outcome(outcome),
    .store_hit(store_hit),
    .hit_total(hit_total),
    .miss_total(miss_total),
    .eviction_total(eviction_total)
  );

endmodule

`default_nettype wire
